[hw/rtl/didtw_pkg.sv]
// ----------------------------------------------------------------------------
// didtw_pkg: shared types, constants and helpers for the idle dimmer
// Register map, power mode codes, sequencer states and the small
// arithmetic helpers used by the serial datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package didtw_pkg;

    // Panel geometry (touch rotation by 180 degrees)
    localparam int PANEL_WIDTH  = 466;
    localparam int PANEL_HEIGHT = 466;
    localparam int PANEL_DIM_W  = 11;          // holds sizes up to 2047

    // Field widths
    localparam int COORD_W   = 9;
    localparam int PCT_W     = 7;
    localparam int SEC_W     = 16;
    localparam int LIFT_W    = 8;
    localparam int LEVEL_W   = 8;
    localparam int IDLE_W    = 32;
    localparam int MS_W      = 26;             // 65535 s * 1000 fits in 26 bits
    localparam int PROD_W    = LEVEL_W + PCT_W; // level * percent
    localparam int REM_W     = 7;              // remainder below 100

    // Serial step counts
    localparam int MUL_STEPS  = PCT_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int TIME_STEPS = SEC_W;
    localparam int STEP_W     = 4;

    localparam logic [MS_W-1:0]    MS_PER_S    = MS_W'(1000);
    localparam logic [REM_W:0]     PCT_DIVISOR = 8'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

    // Configuration register map
    localparam int ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_BRIGHT_PCT = 3'd0,
        REG_DIM_PCT    = 3'd1,
        REG_DIM_AFTER  = 3'd2,
        REG_OFF_AFTER  = 3'd3,
        REG_LIFT_MS    = 3'd4
    } reg_idx_t;

    // Reset values of the registers
    localparam logic [PCT_W-1:0]  RST_BRIGHT_PCT = 7'd100;
    localparam logic [PCT_W-1:0]  RST_DIM_PCT    = 7'd30;
    localparam logic [SEC_W-1:0]  RST_DIM_AFTER  = 16'd60;
    localparam logic [SEC_W-1:0]  RST_OFF_AFTER  = 16'd300;
    localparam logic [LIFT_W-1:0] RST_LIFT_MS    = 8'd150;

    typedef enum logic [1:0] {
        MODE_AWAKE = 2'd0,
        MODE_DIM   = 2'd1,
        MODE_OFF   = 2'd2
    } power_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } seq_state_t;

    // 180 degree rotation of one raw coordinate; at or past the edge gives 0
    function automatic logic [COORD_W-1:0] rotate_coord(
        input logic [COORD_W-1:0]     raw,
        input logic [PANEL_DIM_W-1:0] size
    );
        logic [PANEL_DIM_W-1:0] raw_ext;
        logic [PANEL_DIM_W-1:0] diff;
        raw_ext = PANEL_DIM_W'(raw);
        diff    = size - PANEL_DIM_W'(1) - raw_ext;
        return ((raw_ext + PANEL_DIM_W'(1)) >= size) ? '0 : diff[COORD_W-1:0];
    endfunction

    // Quotient of a percent scale: saturate at full scale, never below 1
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [PROD_W-1:0] q);
        logic [LEVEL_W-1:0] v;
        v = (q > PROD_W'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
        return (v == '0) ? LEVEL_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/display_idle_dimmer_touch_wake_top.sv]
// ----------------------------------------------------------------------------
// display_idle_dimmer_touch_wake_top: panel idle dimmer with touch wake
// Takes one beat per millisecond tick, tracks idle time and power mode,
// filters wake touches and returns one result beat per tick.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input beat is one millisecond tick, optionally carrying a touch
// sample. Every tick returns exactly one result beat with the rotated touch
// point (or released), the power mode and the panel brightness, plus a
// strobe when the brightness differs from the previous tick. A finger seen
// while dimmed or off only wakes the panel and is reported as released until
// no finger has been seen for lift_ms. One tick is worked on at a time.
// The work is done by the bit-serial percent scaler: 7 shift-add steps
// then 15 restoring-division steps by 100, run once for full brightness
// and, when the panel ends dimmed, once more for the dim level. The
// seconds-to-ms conversion of both idle thresholds runs beside the first
// pass (16 steps). A result beat that is not taken holds the block in its
// last step; the next input beat is accepted once the result has moved
// to the output register.
// Registers (APB, byte address 4*index): 0 bright_percent, 1 dim_percent,
// 2 dim_after_s, 3 off_after_s, 4 lift_ms; write them only while idle.

module display_idle_dimmer_touch_wake_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input tick stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // touch_present, touch_x[8:0], touch_y[8:0],
                                        // hold_awake, zero fill
    input  wire logic [0:0]  s_tuser,   // touch_read
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pointer_pressed, pointer_x[8:0], pointer_y[8:0],
                                        // power_mode[1:0], brightness_level[7:0],
                                        // brightness_write, zero fill
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [didtw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [didtw_pkg::PCT_W-1:0]  bright_pct_reg;
    logic [didtw_pkg::PCT_W-1:0]  dim_pct_reg;
    logic [didtw_pkg::SEC_W-1:0]  dim_after_reg;
    logic [didtw_pkg::SEC_W-1:0]  off_after_reg;
    logic [didtw_pkg::LIFT_W-1:0] lift_ms_reg;

    logic                  cfg_wr;
    didtw_pkg::reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = didtw_pkg::reg_idx_t'(paddr[didtw_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_pct_reg <= didtw_pkg::RST_BRIGHT_PCT;
            dim_pct_reg    <= didtw_pkg::RST_DIM_PCT;
            dim_after_reg  <= didtw_pkg::RST_DIM_AFTER;
            off_after_reg  <= didtw_pkg::RST_OFF_AFTER;
            lift_ms_reg    <= didtw_pkg::RST_LIFT_MS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                didtw_pkg::REG_BRIGHT_PCT: bright_pct_reg <= pwdata[didtw_pkg::PCT_W-1:0];
                didtw_pkg::REG_DIM_PCT:    dim_pct_reg    <= pwdata[didtw_pkg::PCT_W-1:0];
                didtw_pkg::REG_DIM_AFTER:  dim_after_reg  <= pwdata[didtw_pkg::SEC_W-1:0];
                didtw_pkg::REG_OFF_AFTER:  off_after_reg  <= pwdata[didtw_pkg::SEC_W-1:0];
                didtw_pkg::REG_LIFT_MS:    lift_ms_reg    <= pwdata[didtw_pkg::LIFT_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            didtw_pkg::REG_BRIGHT_PCT: prdata = 32'(bright_pct_reg);
            didtw_pkg::REG_DIM_PCT:    prdata = 32'(dim_pct_reg);
            didtw_pkg::REG_DIM_AFTER:  prdata = 32'(dim_after_reg);
            didtw_pkg::REG_OFF_AFTER:  prdata = 32'(off_after_reg);
            didtw_pkg::REG_LIFT_MS:    prdata = 32'(lift_ms_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat unpack
    // ------------------------------------------------------------------
    logic                          in_read;
    logic                          in_present;
    logic [didtw_pkg::COORD_W-1:0] in_x;
    logic [didtw_pkg::COORD_W-1:0] in_y;
    logic                          in_hold;
    logic                          in_beat;

    assign in_read    = s_tuser[0];
    assign in_present = s_tdata[0];
    assign in_x       = s_tdata[9:1];
    assign in_y       = s_tdata[18:10];
    assign in_hold    = s_tdata[19];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    didtw_pkg::seq_state_t           state_reg, state_next;
    logic [didtw_pkg::IDLE_W-1:0]    idle_ms_reg, idle_ms_next;
    logic [didtw_pkg::LIFT_W-1:0]    since_touch_reg, since_touch_next;
    logic                            swallow_reg, swallow_next;
    didtw_pkg::power_mode_t          power_reg, power_next;
    logic [didtw_pkg::LEVEL_W-1:0]   panel_level_reg, panel_level_next;

    // per-tick pointer result, captured at the input beat
    logic                            pressed_reg, pressed_next;
    logic [didtw_pkg::COORD_W-1:0]   px_reg, px_next;
    logic [didtw_pkg::COORD_W-1:0]   py_reg, py_next;

    // threshold lanes: seconds shifted out MSB first, ms accumulated
    logic [didtw_pkg::SEC_W-1:0]     dim_s_reg, dim_s_next;
    logic [didtw_pkg::SEC_W-1:0]     off_s_reg, off_s_next;
    logic [didtw_pkg::MS_W-1:0]      dim_ms_reg, dim_ms_next;
    logic [didtw_pkg::MS_W-1:0]      off_ms_reg, off_ms_next;
    logic [didtw_pkg::STEP_W-1:0]    time_cnt_reg, time_cnt_next;
    logic                            time_run_reg, time_run_next;

    // percent scaler: multiplicand, multiplier bits, product / dividend
    logic [didtw_pkg::LEVEL_W-1:0]   mcand_reg, mcand_next;
    logic [didtw_pkg::PCT_W-1:0]     mplier_reg, mplier_next;
    logic [didtw_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [didtw_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [didtw_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                            pass_dim_reg, pass_dim_next;
    didtw_pkg::power_mode_t          mode_reg, mode_next;
    logic [didtw_pkg::LEVEL_W-1:0]   level_reg, level_next;

    // output register
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [31:0]                     m_tdata_reg, m_tdata_next;

    assign s_tready = (state_reg == didtw_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Tick update: timers, swallow filter, pointer report
    // ------------------------------------------------------------------
    logic [didtw_pkg::IDLE_W-1:0] idle_inc;
    logic [didtw_pkg::LIFT_W-1:0] since_inc;
    logic [didtw_pkg::LIFT_W-1:0] since_t;
    logic                         swallow_t;
    logic                         activity;
    logic                         press_t;

    always_comb
    begin
        idle_inc  = (idle_ms_reg == '1) ? idle_ms_reg : idle_ms_reg + 32'd1;
        since_inc = (since_touch_reg == '1) ? since_touch_reg : since_touch_reg + 8'd1;
        since_t   = since_inc;
        swallow_t = swallow_reg;
        activity  = in_hold;
        if (in_read)
        begin
            if (in_present)
            begin
                since_t = '0;
                // wake touch: eat it until the finger has been gone a while
                if (power_reg != didtw_pkg::MODE_AWAKE && !swallow_reg)
                begin
                    swallow_t = 1'b1;
                    activity  = 1'b1;
                end
            end
            else if (since_inc >= lift_ms_reg)
            begin
                swallow_t = 1'b0;
            end
        end
        press_t = in_read && in_present && !swallow_t;
        if (press_t)
        begin
            activity = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Serial datapath steps
    // ------------------------------------------------------------------
    logic [didtw_pkg::REM_W:0]    div_part;
    logic                         div_ge;
    logic [didtw_pkg::PROD_W-1:0] div_acc;
    logic [didtw_pkg::LEVEL_W-1:0] quot_level;
    logic                         off_hit;
    logic                         dim_hit;
    didtw_pkg::power_mode_t       mode_calc;

    always_comb
    begin
        // restoring division by 100, one quotient bit a step
        div_part   = {rem_reg, acc_reg[didtw_pkg::PROD_W-1]};
        div_ge     = (div_part >= didtw_pkg::PCT_DIVISOR);
        div_acc    = {acc_reg[didtw_pkg::PROD_W-2:0], div_ge};
        quot_level = didtw_pkg::clamp_level(div_acc);

        // off wins over dim; a zero threshold never fires
        off_hit = (off_ms_reg != '0) && (idle_ms_reg >= didtw_pkg::IDLE_W'(off_ms_reg));
        dim_hit = (dim_ms_reg != '0) && (idle_ms_reg >= didtw_pkg::IDLE_W'(dim_ms_reg));
        if (off_hit)
            mode_calc = didtw_pkg::MODE_OFF;
        else if (dim_hit)
            mode_calc = didtw_pkg::MODE_DIM;
        else
            mode_calc = didtw_pkg::MODE_AWAKE;
    end

    // ------------------------------------------------------------------
    // Sequencer and next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        idle_ms_next     = idle_ms_reg;
        since_touch_next = since_touch_reg;
        swallow_next     = swallow_reg;
        power_next       = power_reg;
        panel_level_next = panel_level_reg;
        pressed_next     = pressed_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        dim_s_next       = dim_s_reg;
        off_s_next       = off_s_reg;
        dim_ms_next      = dim_ms_reg;
        off_ms_next      = off_ms_reg;
        time_cnt_next    = time_cnt_reg;
        time_run_next    = time_run_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        pass_dim_next    = pass_dim_reg;
        mode_next        = mode_reg;
        level_next       = level_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        // threshold lanes: ms = ms*2 + bit*1000, MSB first
        if (time_run_reg)
        begin
            dim_ms_next = {dim_ms_reg[didtw_pkg::MS_W-2:0], 1'b0}
                        + (dim_s_reg[didtw_pkg::SEC_W-1] ? didtw_pkg::MS_PER_S : '0);
            off_ms_next = {off_ms_reg[didtw_pkg::MS_W-2:0], 1'b0}
                        + (off_s_reg[didtw_pkg::SEC_W-1] ? didtw_pkg::MS_PER_S : '0);
            dim_s_next    = {dim_s_reg[didtw_pkg::SEC_W-2:0], 1'b0};
            off_s_next    = {off_s_reg[didtw_pkg::SEC_W-2:0], 1'b0};
            time_cnt_next = time_cnt_reg + 4'd1;
            if (time_cnt_reg == didtw_pkg::STEP_W'(didtw_pkg::TIME_STEPS - 1))
                time_run_next = 1'b0;
        end

        case (state_reg)
            didtw_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    idle_ms_next     = activity ? '0 : idle_inc;
                    since_touch_next = since_t;
                    swallow_next     = swallow_t;
                    pressed_next     = press_t;
                    px_next = press_t ? didtw_pkg::rotate_coord(in_x,
                              didtw_pkg::PANEL_DIM_W'(didtw_pkg::PANEL_WIDTH)) : '0;
                    py_next = press_t ? didtw_pkg::rotate_coord(in_y,
                              didtw_pkg::PANEL_DIM_W'(didtw_pkg::PANEL_HEIGHT)) : '0;
                    dim_s_next    = dim_after_reg;
                    off_s_next    = off_after_reg;
                    dim_ms_next   = '0;
                    off_ms_next   = '0;
                    time_cnt_next = '0;
                    time_run_next = 1'b1;
                    // first pass: full brightness = 255 * bright% / 100
                    mcand_next    = didtw_pkg::LEVEL_MAX;
                    mplier_next   = bright_pct_reg;
                    acc_next      = '0;
                    step_next     = '0;
                    pass_dim_next = 1'b0;
                    state_next    = didtw_pkg::ST_MUL;
                end
            end

            didtw_pkg::ST_MUL:
            begin
                acc_next = {acc_reg[didtw_pkg::PROD_W-2:0], 1'b0}
                         + (mplier_reg[didtw_pkg::PCT_W-1]
                            ? didtw_pkg::PROD_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[didtw_pkg::PCT_W-2:0], 1'b0};
                step_next   = step_reg + 4'd1;
                if (step_reg == didtw_pkg::STEP_W'(didtw_pkg::MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = didtw_pkg::ST_DIV;
                end
            end

            didtw_pkg::ST_DIV:
            begin
                acc_next  = div_acc;
                rem_next  = div_ge ? didtw_pkg::REM_W'(div_part - didtw_pkg::PCT_DIVISOR)
                                   : div_part[didtw_pkg::REM_W-1:0];
                step_next = step_reg + 4'd1;
                if (step_reg == didtw_pkg::STEP_W'(didtw_pkg::DIV_STEPS - 1))
                begin
                    step_next = '0;
                    if (pass_dim_reg)
                    begin
                        level_next = quot_level;
                        state_next = didtw_pkg::ST_DONE;
                    end
                    else
                    begin
                        mode_next = mode_calc;
                        if (mode_calc == didtw_pkg::MODE_DIM)
                        begin
                            // second pass: dim level = full * dim% / 100
                            mcand_next    = quot_level;
                            mplier_next   = dim_pct_reg;
                            acc_next      = '0;
                            pass_dim_next = 1'b1;
                            state_next    = didtw_pkg::ST_MUL;
                        end
                        else
                        begin
                            level_next = (mode_calc == didtw_pkg::MODE_OFF) ? '0 : quot_level;
                            state_next = didtw_pkg::ST_DONE;
                        end
                    end
                end
            end

            didtw_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = {2'b00, (level_reg != panel_level_reg), level_reg,
                                        mode_reg, py_reg, px_reg, pressed_reg};
                    power_next       = mode_reg;
                    panel_level_next = level_reg;
                    state_next       = didtw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = didtw_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= didtw_pkg::ST_IDLE;
            idle_ms_reg     <= '0;
            since_touch_reg <= '0;
            swallow_reg     <= 1'b0;
            power_reg       <= didtw_pkg::MODE_AWAKE;
            panel_level_reg <= '0;
            time_cnt_reg    <= '0;
            time_run_reg    <= 1'b0;
            step_reg        <= '0;
            pass_dim_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idle_ms_reg     <= idle_ms_next;
            since_touch_reg <= since_touch_next;
            swallow_reg     <= swallow_next;
            power_reg       <= power_next;
            panel_level_reg <= panel_level_next;
            time_cnt_reg    <= time_cnt_next;
            time_run_reg    <= time_run_next;
            step_reg        <= step_next;
            pass_dim_reg    <= pass_dim_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        pressed_reg <= pressed_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        dim_s_reg   <= dim_s_next;
        off_s_reg   <= off_s_next;
        dim_ms_reg  <= dim_ms_next;
        off_ms_reg  <= off_ms_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        mode_reg    <= mode_next;
        level_reg   <= level_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // thresholds must be complete before the first pass picks the mode
    a_time_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == didtw_pkg::ST_DIV && !pass_dim_reg
         && step_reg == didtw_pkg::STEP_W'(didtw_pkg::DIV_STEPS - 1)) |-> !time_run_reg)
        else $error("idle thresholds not ready at mode decision");

    // only the off mode may drive the panel dark
    a_dark_only_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[28:21] == 8'd0) == (m_tdata[20:19] == didtw_pkg::MODE_OFF)))
        else $error("brightness zero does not match off mode");

    // a reported press is never a swallowed touch
    a_press_not_swallowed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != didtw_pkg::ST_IDLE && pressed_reg) |-> !swallow_reg)
        else $error("pressed reported while swallowing");

    // hold_awake restarts the idle timer
    a_hold_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[19]) |=> (idle_ms_reg == '0))
        else $error("idle timer not cleared by hold");
`endif

endmodule

`default_nettype wire
